>>> design/lpce_pkg.sv
package lpce_pkg;

    localparam int CODE_W    = 64;
    localparam int LEN_W     = 7;
    localparam int FIXED_W   = 32;
    localparam int CFG_W     = 6;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [LEN_W-1:0] MAX_LEN   = 7'd64;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

    typedef enum logic {
        MODE_TEXT  = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    // one pending code word; nxt is the index of its next unsent bit
    typedef struct packed {
        logic [LEN_W-1:0]  nxt;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        logic               overflow;
        logic               stack_empty;
        logic               dynamic_bit;
        logic [FIXED_W-1:0] fixed_bits;
    } result_t;

endpackage

>>> design/lpce_ram.sv
module lpce_ram import lpce_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/lpce_out_buf.sv
module lpce_out_buf import lpce_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t head_reg, head_next;
    result_t tail_reg, tail_next;
    logic    head_valid_reg, head_valid_next;
    logic    tail_valid_reg, tail_valid_next;
    logic    push, pop;

    assign in_ready  = !tail_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = head_valid_reg && out_ready;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop) begin
            if (tail_valid_reg) begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end else begin
                head_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!head_valid_next) begin
                head_next       = in_data;
                head_valid_next = 1'b1;
            end else begin
                tail_next       = in_data;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> design/layered_prefix_code_encoder.sv
// A result item is registered in the output buffer before it appears on m_.
// Throughput: one item per cycle unless the output buffer is full; the stack top sits
// in registers and the entry below it is prefetched from the stack RAM every cycle,
// with a bypass after a push. A two-entry output buffer keeps s_tready high while one result waits.
// Reset clears the stack count, the output buffer and sets num_layers to 8;
// the stack RAM is not cleared.
module layered_prefix_code_encoder import lpce_pkg::*; #(
    parameter int MAX_LAYERS  = 32,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,     // num_layers
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // code_bits[63:0], code_len[70:64]
    input  logic [0:0]           s_tuser,       // mode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // fixed_bits[31:0], dynamic_bit[32],
                                                // stack_empty[33], overflow[34]
);

    localparam int AW      = $clog2(STACK_DEPTH);
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int EFF_MAX = (MAX_LAYERS < FIXED_W) ? MAX_LAYERS : FIXED_W;

    logic [CFG_W-1:0] num_layers_reg;
    logic [CW-1:0]    count_reg, count_next;
    entry_t           top_reg, top_next;
    logic             fwd_valid_reg, fwd_valid_next;
    entry_t           fwd_data_reg;

    logic              s_accept, buf_ready;
    mode_t             mode_in;
    logic [CODE_W-1:0] code_in, aligned;
    logic [LEN_W-1:0]  len_raw, len_sat, shamt, nf, l_ext, new_nxt;
    logic [CFG_W-1:0]  l_eff;
    logic [5:0]        new_bit_idx;
    logic              is_text, long_word, full, push_ok, ovf, has_top;
    logic              new_exh, top_exh, top_bit, dyn;
    logic [LEN_W-1:0]  top_idx, top_nxt;
    logic [FIXED_W-1:0] fixed;
    logic [CW-1:0]     cnt_m1, cnt_next_m2;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        rd_entry, second;
    result_t       res;

    assign s_tready = aresetn && buf_ready;
    assign s_accept = s_tvalid && s_tready;

    assign mode_in = mode_t'(s_tuser[0]);
    assign code_in = s_tdata[CODE_W-1:0];
    assign len_raw = s_tdata[CODE_W+LEN_W-1:CODE_W];
    assign len_sat = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    assign l_eff   = (num_layers_reg > CFG_W'(EFF_MAX)) ? CFG_W'(EFF_MAX) : num_layers_reg;
    assign l_ext   = {1'b0, l_eff};

    // first code bit moved to bit 63
    assign shamt   = MAX_LEN - len_sat;
    assign aligned = code_in << shamt;
    assign nf      = (len_sat < l_ext) ? len_sat : l_ext;
    assign is_text = (mode_in == MODE_TEXT);

    always_comb begin
        for (int b = 0; b < FIXED_W; b++) begin
            fixed[b] = is_text && aligned[CODE_W-1-b] && (LEN_W'(b) < nf);
        end
    end

    assign long_word   = is_text && (len_sat > l_ext);
    assign full        = (count_reg >= CW'(STACK_DEPTH));
    assign push_ok     = long_word && !full;
    assign ovf         = long_word && full;
    assign has_top     = (count_reg != '0);

    assign new_bit_idx = 6'(CODE_W - 1) - l_eff;
    assign new_nxt     = l_ext + LEN_W'(1);
    assign new_exh     = (new_nxt >= len_sat);

    assign top_idx = top_reg.len - LEN_W'(1) - top_reg.nxt;
    assign top_bit = top_reg.code[top_idx[5:0]];
    assign top_nxt = top_reg.nxt + LEN_W'(1);
    assign top_exh = (top_nxt >= top_reg.len);

    assign second  = fwd_valid_reg ? fwd_data_reg : rd_entry;
    assign cnt_m1  = count_reg - CW'(1);
    assign wr_addr = cnt_m1[AW-1:0];

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        dyn        = 1'b0;
        if (s_accept) begin
            if (push_ok) begin
                dyn = aligned[new_bit_idx];
                if (!new_exh) begin
                    count_next = count_reg + CW'(1);
                    top_next   = '{nxt: new_nxt, len: len_sat, code: code_in};
                    wr_en      = has_top;
                end
            end else if (has_top) begin
                dyn = top_bit;
                if (top_exh) begin
                    count_next = cnt_m1;
                    top_next   = second;
                end else begin
                    top_next.nxt = top_nxt;
                end
            end
        end
    end

    // keep the entry below the next top on the RAM read port
    assign cnt_next_m2    = count_next - CW'(2);
    assign rd_addr        = cnt_next_m2[AW-1:0];
    assign fwd_valid_next = wr_en && (wr_addr == rd_addr);

    assign res.fixed_bits  = fixed;
    assign res.dynamic_bit = dyn;
    assign res.stack_empty = (count_next == '0);
    assign res.overflow    = ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_layers_reg <= CFG_RESET;
            count_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_layers_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            fwd_valid_reg <= fwd_valid_next;
        end
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
    end

    lpce_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    result_t out_res;

    lpce_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_res};

    ap_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    ap_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && ovf |-> count_reg == CW'(STACK_DEPTH))
        else $error("overflow flagged with room on stack");

    ap_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("stack count moved without an item");

    ap_spill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("top spilled to RAM without stack growth");

endmodule
